// ----- sv/raster_to_page_display_feed_defines.svh -----
// ----------------------------------------------------------------------------
// Raster to page display feed: assertion macros
// Shared concurrent assertion helpers for the checker.
// ----------------------------------------------------------------------------
`ifndef RASTER_TO_PAGE_DISPLAY_FEED_DEFINES_SVH
`define RASTER_TO_PAGE_DISPLAY_FEED_DEFINES_SVH

// same-cycle implication
`define RTPDF_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTPDF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/rtpdf_pkg.sv -----
// ----------------------------------------------------------------------------
// Raster to page display feed package
// Opcodes, phase and state codes, constants and inter-module structs.
// ----------------------------------------------------------------------------
package rtpdf_pkg;

  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned StoreAddrW = 10;

  localparam logic [7:0] PageCmd        = 8'hB0;
  localparam logic [7:0] ColHighCmd     = 8'h10;
  localparam logic [7:0] ColOffsetReset = 8'h02;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_PULL  = 1'b1
  } op_e;

  // transmit stream position inside one page
  typedef enum logic [1:0] {
    PH_PAGE   = 2'd0,
    PH_COL_LO = 2'd1,
    PH_COL_HI = 2'd2,
    PH_DATA   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_GATHER = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic       start;
    logic [2:0] page;
    logic [6:0] col;
  } gather_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] data;
  } gather_rsp_t;

endpackage

// ----- sv/rtpdf_if.sv -----
// ----------------------------------------------------------------------------
// Raster to page display feed channels
// Input item channel and transmit byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rtpdf_in_if
  import rtpdf_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [StoreAddrW-1:0] address;
  logic [7:0]            pixels;

  modport source (output valid, output opcode, output address, output pixels, input ready);
  modport sink   (input valid, input opcode, input address, input pixels, output ready);
endinterface

interface rtpdf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       is_data;
  logic       frame_end;

  modport source (output valid, output tx_byte, output is_data, output frame_end, input ready);
  modport sink   (input valid, input tx_byte, input is_data, input frame_end, output ready);
endinterface

// ----- sv/raster_to_page_display_feed.sv -----
// ----------------------------------------------------------------------------
// Raster to page display feed
// 1 bpp row-major frame store streamed out as page-mode panel bytes.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries items: opcode 0 stores pixels at a source byte address,
//   opcode 1 pulls the next transmit byte. Each pull gives one beat on out_o:
//   per page the page address command, the two column address commands
//   (from the column offset register, written via cfg_we_i/cfg_wdata_i),
//   then WIDTH column data bytes with is_data high; frame_end marks the last
//   data byte of the frame.
//   A store writes the frame store on accept; a command pull's beat shows on
//   out_o the cycle after accept. A data pull goes through the gather unit,
//   which reads eight source bytes through the single RAM read port, one per
//   cycle; the byte then passes the RAM read, gather result and output registers.
//   One item is in work at a time. in_i.ready drops while a data byte is
//   gathered, and while an output beat is stalled by out_o.ready low.
//   After reset the frame store is zeroed by a sweep over all 1024 entries,
//   one entry per cycle; no item is accepted during it, config writes still land.
// ----------------------------------------------------------------------------
module raster_to_page_display_feed
  import rtpdf_pkg::*;
#(
  parameter int unsigned WIDTH  = 128,
  parameter int unsigned HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtpdf_in_if.sink    in_i,
  rtpdf_out_if.source out_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  logic                  wr_en;
  logic [StoreAddrW-1:0] wr_addr;
  logic [7:0]            wr_data;
  logic                  rd_en;
  logic [StoreAddrW-1:0] rd_addr;
  logic [7:0]            rd_data;
  gather_req_t           req;
  gather_rsp_t           rsp;

  rtpdf_ctrl #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .req_o      (req),
    .rsp_i      (rsp)
  );

  rtpdf_gather #(
    .WIDTH (WIDTH),
    .HEIGHT(HEIGHT)
  ) u_gather (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .rsp_o    (rsp),
    .rd_en_o  (rd_en),
    .rd_addr_o(rd_addr),
    .rd_data_i(rd_data)
  );

  rtpdf_ram #(
    .Width(8),
    .Depth(StoreDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

endmodule

// ----- sv/rtpdf_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rtpdf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/rtpdf_gather.sv -----
// ----------------------------------------------------------------------------
// Column gather unit
// Reads eight source bytes, one per cycle, and packs one pixel column.
// ----------------------------------------------------------------------------
module rtpdf_gather
  import rtpdf_pkg::*;
#(
  parameter int unsigned WIDTH  = 128,
  parameter int unsigned HEIGHT = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gather_req_t           req_i,
  output gather_rsp_t           rsp_o,
  output logic                  rd_en_o,
  output logic [StoreAddrW-1:0] rd_addr_o,
  input  logic [7:0]            rd_data_i
);

  localparam int unsigned RowBytes = WIDTH / 8;
  localparam logic [6:0]  HeightL  = 7'(HEIGHT);

  logic       active_q, active_d;
  logic [2:0] bit_q, bit_d;
  logic [2:0] page_q, page_d;
  logic [6:0] col_q, col_d;
  logic       pend_q, pend_d;
  logic [2:0] pend_bit_q, pend_bit_d;
  logic       pend_ok_q, pend_ok_d;
  logic [7:0] acc_q, acc_d;
  logic       done_q, done_d;
  logic [7:0] data_q, data_d;
  logic [5:0] row;
  logic       pix;

  assign row       = {page_q, bit_q};
  assign rd_en_o   = active_q;
  assign rd_addr_o = StoreAddrW'((row * RowBytes) + col_q[6:3]);

  // leftmost pixel is bit 7 of the source byte
  assign pix = pend_ok_q & rd_data_i[~col_q[2:0]];

  always_comb begin
    active_d   = active_q;
    bit_d      = bit_q;
    page_d     = page_q;
    col_d      = col_q;
    acc_d      = acc_q;
    data_d     = data_q;
    pend_d     = active_q;
    pend_bit_d = bit_q;
    pend_ok_d  = {1'b0, row} < HeightL;
    done_d     = pend_q && (pend_bit_q == 3'd7);

    if (pend_q) begin
      acc_d = acc_q | (8'(pix) << pend_bit_q);
    end
    if (done_d) begin
      data_d = acc_d;
    end
    if (active_q) begin
      if (bit_q == 3'd7) begin
        active_d = 1'b0;
      end else begin
        bit_d = bit_q + 3'd1;
      end
    end
    if (req_i.start) begin
      active_d = 1'b1;
      bit_d    = 3'd0;
      page_d   = req_i.page;
      col_d    = req_i.col;
      acc_d    = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
      bit_q    <= 3'd0;
    end else begin
      active_q <= active_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
      bit_q    <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q     <= page_d;
    col_q      <= col_d;
    pend_bit_q <= pend_bit_d;
    pend_ok_q  <= pend_ok_d;
    acc_q      <= acc_d;
    data_q     <= data_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.data = data_q;

endmodule

// ----- sv/rtpdf_ctrl.sv -----
// ----------------------------------------------------------------------------
// Feed controller
// Store clearing sweep, page/column sequencing, command bytes, output beat.
// ----------------------------------------------------------------------------
module rtpdf_ctrl
  import rtpdf_pkg::*;
#(
  parameter int unsigned WIDTH  = 128,
  parameter int unsigned HEIGHT = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rtpdf_in_if.sink              in_i,
  rtpdf_out_if.source           out_o,
  input  logic                  cfg_we_i,
  input  logic [7:0]            cfg_wdata_i,
  output logic                  wr_en_o,
  output logic [StoreAddrW-1:0] wr_addr_o,
  output logic [7:0]            wr_data_o,
  output gather_req_t           req_o,
  input  gather_rsp_t           rsp_i
);

  localparam int unsigned Pages = (HEIGHT + 7) / 8;
  localparam int unsigned ColW  = $clog2(WIDTH);

  ctrl_state_e           state_q, state_d;
  phase_e                phase_q, phase_d;
  logic [2:0]            page_q, page_d;
  logic [ColW-1:0]       column_q, column_d;
  logic [StoreAddrW-1:0] clr_q, clr_d;
  logic [7:0]            offset_q;
  logic                  fe_pend_q, fe_pend_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            tx_q, tx_d;
  logic                  is_data_q, is_data_d;
  logic                  frame_end_q, frame_end_d;
  logic                  accept;
  logic                  last_col;
  logic                  last_page;

  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;
  assign last_col   = column_q == ColW'(WIDTH - 1);
  assign last_page  = page_q == 3'(Pages - 1);

  assign wr_en_o   = (state_q == ST_CLEAR) || (accept && (in_i.opcode == OP_STORE));
  assign wr_addr_o = (state_q == ST_CLEAR) ? clr_q : in_i.address;
  assign wr_data_o = (state_q == ST_CLEAR) ? 8'h00 : in_i.pixels;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    page_d      = page_q;
    column_d    = column_q;
    clr_d       = clr_q;
    fe_pend_d   = fe_pend_q;
    tx_d        = tx_q;
    is_data_d   = is_data_q;
    frame_end_d = frame_end_q;
    out_valid_d = out_valid_q && !out_o.ready;
    req_o.start = 1'b0;
    req_o.page  = page_q;
    req_o.col   = 7'(column_q);

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + StoreAddrW'(1);
        if (clr_q == StoreAddrW'(StoreDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (in_i.opcode == OP_PULL)) begin
          is_data_d   = 1'b0;
          frame_end_d = 1'b0;
          unique case (phase_q)
            PH_PAGE: begin
              tx_d        = PageCmd + {5'd0, page_q};
              out_valid_d = 1'b1;
              phase_d     = PH_COL_LO;
            end
            PH_COL_LO: begin
              tx_d        = {4'h0, offset_q[3:0]};
              out_valid_d = 1'b1;
              phase_d     = PH_COL_HI;
            end
            PH_COL_HI: begin
              tx_d        = ColHighCmd | {4'h0, offset_q[7:4]};
              out_valid_d = 1'b1;
              phase_d     = PH_DATA;
            end
            PH_DATA: begin
              req_o.start = 1'b1;
              fe_pend_d   = last_col && last_page;
              state_d     = ST_GATHER;
              if (last_col) begin
                column_d = '0;
                phase_d  = PH_PAGE;
                page_d   = last_page ? 3'd0 : page_q + 3'd1;
              end else begin
                column_d = column_q + ColW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_GATHER: begin
        // output slot was free at accept, nothing else fills it meanwhile
        if (rsp_i.done) begin
          tx_d        = rsp_i.data;
          is_data_d   = 1'b1;
          frame_end_d = fe_pend_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      phase_q     <= PH_PAGE;
      page_q      <= 3'd0;
      column_q    <= '0;
      clr_q       <= '0;
      offset_q    <= ColOffsetReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      page_q      <= page_d;
      column_q    <= column_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        offset_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fe_pend_q   <= fe_pend_d;
    tx_q        <= tx_d;
    is_data_q   <= is_data_d;
    frame_end_q <= frame_end_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.tx_byte   = tx_q;
  assign out_o.is_data   = is_data_q;
  assign out_o.frame_end = frame_end_q;

endmodule

// ----- sv/rtpdf_checker.sv -----
// ----------------------------------------------------------------------------
// Raster to page display feed checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "raster_to_page_display_feed_defines.svh"

module rtpdf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_tx_byte_i,
  input logic       out_is_data_i,
  input logic       out_frame_end_i
);

  // frame end only ever tags a data byte
  `RTPDF_ASSERT_SAME(a_fe_on_data, clk_i, rst_ni, out_valid_i && !out_is_data_i, !out_frame_end_i, "frame_end on command byte")

  // no item taken while a finished beat is held back
  `RTPDF_ASSERT_SAME(a_no_accept_on_stall, clk_i, rst_ni, in_valid_i && in_ready_i, !out_valid_i || out_ready_i, "accept while output stalled")

  // a stalled beat keeps its contents
  `RTPDF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_tx_byte_i) && $stable(out_is_data_i) && $stable(out_frame_end_i), "output beat changed while stalled")

endmodule

bind raster_to_page_display_feed rtpdf_checker u_rtpdf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_tx_byte_i  (out_o.tx_byte),
  .out_is_data_i  (out_o.is_data),
  .out_frame_end_i(out_o.frame_end)
);
